>>> hdl/slbgr_pkg.sv
package slbgr_pkg;

  localparam int VAL_W     = 31;
  localparam int REM_W     = 10;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_AW    = 3;

  localparam logic [REM_W-1:0] REM_MAX = 10'd1023;
  localparam logic [CFG_AW-1:0] ADDR_GAP_LIMIT = 3'd0;

  typedef logic [VAL_W-1:0] val_t;

endpackage

>>> hdl/sorted_longest_bounded_gap_run.sv
// Sorted longest bounded-gap run.
// Values arrive on the in_ stream channel, one per transaction, and tlast
// marks the final value of a set. Each value is placed in sorted position in
// an on-chip memory by an insertion pass that moves one larger entry up per
// cycle; the single memory read port sets that pace, as each step must read
// the next entry down. On the last value the sorted set is read out once,
// one entry per cycle from the registered read port, and the longest run
// whose neighbouring gaps stay within gap_limit is found.
// One result transaction then carries the number of values to remove and an
// overflow flag, set when more than MAX_ITEMS values arrived and the excess
// was dropped. gap_limit is written through the cfg_ APB port at address 0.
// Reset (synchronous, active low) empties the set, clears the overflow flag
// and gap_limit, and drops any pending result; the memory is not cleared.
// While the receiver stalls the result is held in the output register and
// the next set may already load; a further result waits until it is taken.
module sorted_longest_bounded_gap_run #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [30:0] value, [31] zero
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [slbgr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  // out_tdata: [9:0] removals, [15:10] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [slbgr_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: [0] overflow
  output logic                             out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [slbgr_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_WRV  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 last_r, last_nxt;
  slbgr_pkg::val_t      v_r, v_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        iss_r, iss_nxt;
  logic [CW-1:0]        arr_r, arr_nxt;
  logic                 rvalid_r, rvalid_nxt;
  slbgr_pkg::val_t      prev_r, prev_nxt;
  logic [CW-1:0]        cur_r, cur_nxt;
  logic [CW-1:0]        best_r, best_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [slbgr_pkg::REM_W-1:0] out_rem_r, out_rem_nxt;
  logic                 out_ovf_r, out_ovf_nxt;
  slbgr_pkg::val_t      gap_r;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  slbgr_pkg::val_t      wdata, rdata;
  slbgr_pkg::val_t      diff;
  logic [CW-1:0]        rem_full;
  logic                 in_acc;

  slbgr_ram #(.AW(AW), .DW(slbgr_pkg::VAL_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Configuration port: always ready, one register.
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == slbgr_pkg::ADDR_GAP_LIMIT) begin
      gap_r <= cfg_pwdata[slbgr_pkg::VAL_W-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == slbgr_pkg::ADDR_GAP_LIMIT) ? {1'b0, gap_r} : 32'd0;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign diff      = rdata - prev_r;
  assign rem_full  = count_r - best_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    v_nxt         = v_r;
    pos_nxt       = pos_r;
    iss_nxt       = iss_r;
    arr_nxt       = arr_r;
    rvalid_nxt    = 1'b0;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rem_nxt   = out_rem_r;
    out_ovf_nxt   = out_ovf_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = v_r;
    raddr         = '0;

    case (state_r)
      S_IDLE: begin
        iss_nxt = '0;
        arr_nxt = '0;
        if (in_acc) begin
          last_nxt = in_tlast;
          v_nxt    = in_tdata[slbgr_pkg::VAL_W-1:0];
          if (count_r == MAX_CNT) begin
            ovf_nxt = 1'b1;
            if (in_tlast) begin
              state_nxt = S_SCAN;
            end
          end else if (count_r == '0) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = in_tdata[slbgr_pkg::VAL_W-1:0];
            count_nxt = CW'(1);
            if (in_tlast) begin
              state_nxt = S_SCAN;
            end
          end else begin
            pos_nxt   = count_r[AW-1:0];
            raddr     = AW'(count_r - CW'(1));
            state_nxt = S_INS;
          end
        end
      end
      S_INS: begin
        // rdata holds the entry just below pos_r.
        we    = 1'b1;
        waddr = pos_r;
        if (rdata > v_r) begin
          wdata = rdata;
          if (pos_r == AW'(1)) begin
            pos_nxt   = '0;
            state_nxt = S_WRV;
          end else begin
            raddr   = pos_r - AW'(2);
            pos_nxt = pos_r - AW'(1);
          end
        end else begin
          wdata     = v_r;
          count_nxt = count_r + CW'(1);
          state_nxt = last_r ? S_SCAN : S_IDLE;
        end
      end
      S_WRV: begin
        we        = 1'b1;
        waddr     = pos_r;
        wdata     = v_r;
        count_nxt = count_r + CW'(1);
        state_nxt = last_r ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (iss_r < count_r) begin
          raddr      = iss_r[AW-1:0];
          rvalid_nxt = 1'b1;
          iss_nxt    = iss_r + CW'(1);
        end
        if (rvalid_r) begin
          prev_nxt = rdata;
          arr_nxt  = arr_r + CW'(1);
          if (arr_r == '0) begin
            cur_nxt  = CW'(1);
            best_nxt = CW'(1);
          end else begin
            cur_nxt = (diff > gap_r) ? CW'(1) : cur_r + CW'(1);
            if (cur_nxt > best_r) begin
              best_nxt = cur_nxt;
            end
          end
          if (arr_r + CW'(1) == count_r) begin
            state_nxt = S_RES;
          end
        end
      end
      S_RES: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_rem_nxt   = (rem_full > CW'(slbgr_pkg::REM_MAX)) ? slbgr_pkg::REM_MAX
                                                               : slbgr_pkg::REM_W'(rem_full);
          out_ovf_nxt   = ovf_r;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      arr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      arr_r       <= arr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r    <= last_nxt;
    v_r       <= v_nxt;
    pos_r     <= pos_nxt;
    prev_r    <= prev_nxt;
    cur_r     <= cur_nxt;
    best_r    <= best_nxt;
    out_rem_r <= out_rem_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(slbgr_pkg::OUT_DATA_W - slbgr_pkg::REM_W){1'b0}}, out_rem_r};
  assign out_tuser  = out_ovf_r;

endmodule

>>> hdl/slbgr_ram.sv
module slbgr_ram #(
  parameter int AW = 10,
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  // Simple dual-port store: one write and one registered read each cycle.
  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/slbgr_checker.sv
module slbgr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("reset left a result or a busy input");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:10] == 6'd0)
    else $error("padding bits of the result are not zero");

endmodule

bind sorted_longest_bounded_gap_run slbgr_checker u_slbgr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
